[hw/rtl/rmc_pkg.sv]
// Package for the refcounted mapping cache: sizes, status codes and beat types.
// Used by rmc_cell, rmc_chain and refcounted_mapping_cache_core.
package rmc_pkg;

    localparam int ENTRIES    = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = 48;
    localparam int DEV_W      = 32;
    localparam int CNT_W      = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [2:0] ST_HIT           = 3'd0;
    localparam logic [2:0] ST_FILLED        = 3'd1;
    localparam logic [2:0] ST_IMPORT_FAILED = 3'd2;
    localparam logic [2:0] ST_VICTIM_BUSY   = 3'd3;
    localparam logic [2:0] ST_RELEASED      = 3'd4;
    localparam logic [2:0] ST_NOT_MAPPED    = 3'd5;
    localparam logic [2:0] ST_UNREFERENCED  = 3'd6;
    localparam logic [2:0] ST_OVERFLOW      = 3'd7;

    typedef struct packed {
        logic              command;
        logic [DEV_W-1:0]  dev_id;
        logic [ADDR_W-1:0] io_address;
        logic              import_ok;
        logic [ADDR_W-1:0] release_address;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        slot;
        logic [ADDR_W-1:0] mapped_address;
    } t_out_beat;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] page;
    } t_pick;

    typedef struct packed {
        t_pick             above;
        t_pick             any;
        t_pick             owner;
        logic [CNT_W-1:0]  vic_cnt;
        logic [ADDR_W-1:0] vic_page;
    } t_link;

    typedef struct packed {
        logic              inc;
        logic              dec;
        logic              fill;
        logic [SLOT_W-1:0] slot;
        logic [DEV_W-1:0]  dev_id;
        logic [ADDR_W-1:0] io_address;
    } t_upd;

endpackage

[hw/rtl/rmc_cell.sv]
// One cache entry: tags, reference count, page address and match flags.
// Passes the search link on to its neighbor. Depends on rmc_pkg.
module rmc_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rmc_pkg::SLOT_W-1:0]   i_index,
    input  logic [rmc_pkg::SLOT_W-1:0]   i_victim,
    input  logic [rmc_pkg::ADDR_W-1:0]   i_base,
    input  logic                         i_match_en,
    input  rmc_pkg::t_in_beat            i_req,
    input  rmc_pkg::t_upd                i_upd,
    input  rmc_pkg::t_link               i_link,
    output rmc_pkg::t_link               o_link
);

    logic [rmc_pkg::DEV_W-1:0]  r_tag_dev;
    logic [rmc_pkg::ADDR_W-1:0] r_tag_io;
    logic [rmc_pkg::CNT_W-1:0]  r_count;
    logic [rmc_pkg::ADDR_W-1:0] r_page;
    logic                       r_tag_hit;
    logic                       r_page_hit;
    rmc_pkg::t_pick             mine;
    logic                       upd_here;

    assign upd_here = (i_upd.slot == i_index);

    always_ff @(posedge i_clk) begin
        r_page <= i_base + (rmc_pkg::ADDR_W'(i_index) << rmc_pkg::PAGE_SHIFT);
        if (!i_rst_n) begin
            r_tag_dev  <= '1;
            r_tag_io   <= '0;
            r_count    <= '0;
            r_tag_hit  <= 1'b0;
            r_page_hit <= 1'b0;
        end else begin
            if (i_match_en) begin
                r_tag_hit  <= (r_tag_dev == i_req.dev_id) && (r_tag_io == i_req.io_address);
                r_page_hit <= (r_page == i_req.release_address);
            end
            if (upd_here) begin
                if (i_upd.fill) begin
                    r_tag_dev <= i_upd.dev_id;
                    r_tag_io  <= i_upd.io_address;
                    r_count   <= rmc_pkg::CNT_W'(1);
                end else if (i_upd.inc) begin
                    r_count <= r_count + rmc_pkg::CNT_W'(1);
                end else if (i_upd.dec) begin
                    r_count <= r_count - rmc_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        mine.hit  = 1'b1;
        mine.slot = i_index;
        mine.cnt  = r_count;
        mine.page = r_page;
        o_link = i_link;
        if (!i_link.above.hit && r_tag_hit && (i_index > i_victim)) begin
            o_link.above = mine;
        end
        if (!i_link.any.hit && r_tag_hit) begin
            o_link.any = mine;
        end
        if (!i_link.owner.hit && r_page_hit) begin
            o_link.owner = mine;
        end
        if (i_index == i_victim) begin
            o_link.vic_cnt  = r_count;
            o_link.vic_page = r_page;
        end
    end

endmodule

[hw/rtl/rmc_chain.sv]
// Row of cache cells linked in index order for the first-match search.
// Depends on rmc_pkg and rmc_cell.
module rmc_chain (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rmc_pkg::SLOT_W-1:0]   i_victim,
    input  logic [rmc_pkg::ADDR_W-1:0]   i_base,
    input  logic                         i_match_en,
    input  rmc_pkg::t_in_beat            i_req,
    input  rmc_pkg::t_upd                i_upd,
    output rmc_pkg::t_link               o_link
);

    rmc_pkg::t_link links [rmc_pkg::ENTRIES+1];

    assign links[0] = '0;
    assign o_link   = links[rmc_pkg::ENTRIES];

    for (genvar g = 0; g < rmc_pkg::ENTRIES; g++) begin : g_cell
        rmc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (rmc_pkg::SLOT_W'(g)),
            .i_victim   (i_victim),
            .i_base     (i_base),
            .i_match_en (i_match_en),
            .i_req      (i_req),
            .i_upd      (i_upd),
            .i_link     (links[g]),
            .o_link     (links[g+1])
        );
    end

endmodule

[hw/rtl/refcounted_mapping_cache_core.sv]
// Refcounted mapping cache: a fully associative table of page mappings with
// round robin replacement. A request is captured in S_IDLE, the cells register
// their tag and page compares in S_MATCH, and S_RESOLVE resolves the first
// match along the cell chain and updates the entry, waiting there while the
// output register holds a stalled result. The input stalls outside S_IDLE, so
// a new beat is taken only after the result is written to the output register.
// Depends on rmc_pkg and rmc_chain.
module refcounted_mapping_cache_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmc_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rmc_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rmc_pkg::t_out_beat            o_out_beat
);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_MATCH   = 3'b010,
        S_RESOLVE = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [rmc_pkg::ADDR_W-1:0]  r_base;
    logic [rmc_pkg::SLOT_W-1:0]  r_victim;
    logic [rmc_pkg::SLOT_W-1:0]  n_victim;
    rmc_pkg::t_in_beat           r_req;
    rmc_pkg::t_out_beat          r_out;
    rmc_pkg::t_out_beat          n_out;
    logic                        r_out_valid;
    rmc_pkg::t_upd               upd;
    rmc_pkg::t_link              link;
    rmc_pkg::t_pick              win;
    logic                        go;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign go          = (r_state == S_RESOLVE) && (!r_out_valid || !i_out_stall);

    rmc_chain u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_victim   (r_victim),
        .i_base     (r_base),
        .i_match_en (r_state == S_MATCH),
        .i_req      (r_req),
        .i_upd      (upd),
        .o_link     (link)
    );

    always_comb begin
        win      = link.above.hit ? link.above : link.any;
        n_out    = '0;
        n_victim = r_victim;
        upd            = '0;
        upd.dev_id     = r_req.dev_id;
        upd.io_address = r_req.io_address;
        if (r_req.command == rmc_pkg::CMD_GET) begin
            if (win.hit) begin
                n_out.slot = 4'(win.slot);
                upd.slot   = win.slot;
                if (win.cnt == rmc_pkg::COUNT_MAX) begin
                    n_out.status = rmc_pkg::ST_OVERFLOW;
                end else begin
                    n_out.status         = rmc_pkg::ST_HIT;
                    n_out.mapped_address = win.page;
                    upd.inc              = go;
                end
            end else begin
                n_out.slot = 4'(r_victim);
                upd.slot   = r_victim;
                if (link.vic_cnt != '0) begin
                    n_out.status = rmc_pkg::ST_VICTIM_BUSY;
                end else if (!r_req.import_ok) begin
                    n_out.status = rmc_pkg::ST_IMPORT_FAILED;
                end else begin
                    n_out.status         = rmc_pkg::ST_FILLED;
                    n_out.mapped_address = link.vic_page;
                    upd.fill             = go;
                    n_victim = (r_victim == '0) ? rmc_pkg::LAST_SLOT
                                                : r_victim - rmc_pkg::SLOT_W'(1);
                end
            end
        end else begin
            if (link.owner.hit) begin
                n_out.slot = 4'(link.owner.slot);
                upd.slot   = link.owner.slot;
                if (link.owner.cnt == '0) begin
                    n_out.status = rmc_pkg::ST_UNREFERENCED;
                end else begin
                    n_out.status = rmc_pkg::ST_RELEASED;
                    upd.dec      = go;
                end
            end else begin
                n_out.status = rmc_pkg::ST_NOT_MAPPED;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_beat;
        end
        if (go) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_victim    <= rmc_pkg::LAST_SLOT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            if (go) begin
                r_victim    <= n_victim;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_victim_moves_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_victim != $past(r_victim)) |-> $past(upd.fill))
        else $error("victim pointer moved without a fill");

    a_update_in_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd.inc || upd.dec || upd.fill) |-> (r_state == S_RESOLVE && go
            && $onehot({upd.inc, upd.dec, upd.fill})))
        else $error("entry update outside of resolve");

    a_result_after_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESOLVE))
        else $error("result beat without a resolved request");

    a_failure_has_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != rmc_pkg::ST_HIT
            && r_out.status != rmc_pkg::ST_FILLED) |-> (r_out.mapped_address == '0))
        else $error("address on a result that maps nothing");

endmodule
